// ===== rtl/core/ldmc_pkg.sv =====
`timescale 1ns / 1ps

package ldmc_pkg;

  localparam int unsigned LevelW  = 8;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned MinuteW = 16;
  localparam int unsigned AmountW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  // wide enough for brightness plus or minus any amount
  localparam int unsigned CalcW   = 18;

  localparam logic [ModeW-1:0]   ModeWarm   = 3'd4;
  localparam logic [ModeW-1:0]   ModeLast   = 3'd4;
  localparam logic [LevelW-1:0]  WarmLevel  = 8'd75;
  localparam logic [MinuteW-1:0] MinuteSat  = 16'hFFFF;

  localparam logic [LevelW-1:0]  MaxBrightRst = 8'd255;
  localparam logic [ModeW-1:0]   ModeLimitRst = 3'd4;
  localparam logic [MinuteW-1:0] OffTimeRst   = 16'd60;

  typedef enum logic [3:0] {
    OP_REFRESH    = 4'd0,
    OP_SET_BRIGHT = 4'd1,
    OP_INC        = 4'd2,
    OP_DEC        = 4'd3,
    OP_SET_POWER  = 4'd4,
    OP_TOGGLE     = 4'd5,
    OP_NEXT       = 4'd6,
    OP_PREV       = 4'd7,
    OP_TICK       = 4'd8,
    OP_TIMER_ON   = 4'd9,
    OP_TIMER_OFF  = 4'd10
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_BRIGHT = 2'd0,
    CFG_MODE_LIMIT = 2'd1,
    CFG_OFF_TIME   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0]  max_bright;
    logic [ModeW-1:0]   mode_limit;
    logic [MinuteW-1:0] off_time;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t              colour;
    logic [LevelW-1:0] level;
    logic              power;
    logic [ModeW-1:0]  mode;
  } status_t;

  // colour table, modes past warm are never loaded
  function automatic rgb_t mode_colour(input logic [ModeW-1:0] mode);
    rgb_t c;
    case (mode)
      3'd0:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      3'd1:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      3'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      3'd3:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      3'd4:    c = '{red: 8'd255, green: 8'd75,  blue: 8'd40};
      default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

  // x / 255 for any x up to 255 * 255
  function automatic logic [LevelW-1:0] div255(input logic [2*LevelW-1:0] x);
    logic [2*LevelW:0] s;
    s = {1'b0, x} + {{(LevelW+1){1'b0}}, x[2*LevelW-1:LevelW]} + 1'b1;
    return s[2*LevelW-1:LevelW];
  endfunction

endpackage

// ===== rtl/core/ldmc_if.sv =====
`timescale 1ns / 1ps

interface ldmc_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [15:0] amount;

  modport source (output valid, output opcode, output amount, input ready);
  modport sink   (input valid, input opcode, input amount, output ready);
endinterface

interface ldmc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive_red;
  logic [7:0] drive_green;
  logic [7:0] drive_blue;
  logic [7:0] level_now;
  logic       power_on;
  logic [2:0] mode_now;

  modport source (output valid, output drive_red, output drive_green, output drive_blue,
                  output level_now, output power_on, output mode_now, input ready);
  modport sink   (input valid, input drive_red, input drive_green, input drive_blue,
                  input level_now, input power_on, input mode_now, output ready);
endinterface

// ===== rtl/core/ldmc_state.sv =====
`timescale 1ns / 1ps

module ldmc_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ldmc_pkg::cfg_t                cfg_i,
  input  logic                          upd_i,
  input  logic [3:0]                    op_i,
  input  logic signed [15:0]            amount_i,
  output ldmc_pkg::status_t             status_o
);
  import ldmc_pkg::*;

  rgb_t               colour_q, colour_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic               power_q, power_d;
  logic [ModeW-1:0]   mode_q, mode_d;
  logic [MinuteW-1:0] idle_q, idle_d;
  logic               done_q, done_d;

  logic signed [CalcW-1:0] calc;
  logic signed [CalcW-1:0] base;
  logic signed [CalcW-1:0] amt_x;
  logic                    load;

  always_comb begin
    colour_d = colour_q;
    power_d  = power_q;
    mode_d   = mode_q;
    idle_d   = idle_q;
    done_d   = done_q;
    load     = 1'b0;
    amt_x    = CalcW'(amount_i);
    base     = $signed({{(CalcW-LevelW){1'b0}}, level_q});

    case (op_i)
      OP_NEXT: begin
        mode_d = (mode_q < cfg_i.mode_limit) ? mode_q + 1'b1 : '0;
        load   = 1'b1;
      end
      OP_PREV: begin
        mode_d = (mode_q != '0) ? mode_q - 1'b1 : cfg_i.mode_limit;
        load   = 1'b1;
      end
      default: ;
    endcase

    // entering a table mode reloads the colour, warm also sets the level
    if (load && mode_d <= ModeLast) begin
      colour_d = mode_colour(mode_d);
      if (mode_d == ModeWarm) begin
        base = $signed({{(CalcW-LevelW){1'b0}}, WarmLevel});
      end
    end

    calc = base;
    case (op_i)
      OP_SET_BRIGHT: calc = amt_x;
      OP_INC:        calc = base + amt_x;
      OP_DEC:        calc = base - amt_x;
      OP_SET_POWER:  power_d = amount_i[0];
      OP_TOGGLE:     power_d = ~power_q;
      OP_TICK: begin
        if (idle_q > cfg_i.off_time && !done_q) begin
          done_d  = 1'b1;
          power_d = 1'b0;
        end else if (idle_q != MinuteSat) begin
          idle_d = idle_q + 1'b1;
        end
      end
      OP_TIMER_ON: begin
        done_d = 1'b0;
        idle_d = '0;
      end
      OP_TIMER_OFF:  done_d = 1'b1;
      default: ;
    endcase

    if (calc > $signed({{(CalcW-LevelW){1'b0}}, cfg_i.max_bright})) begin
      level_d = cfg_i.max_bright;
    end else if (calc < 0) begin
      level_d = '0;
    end else begin
      level_d = calc[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= '0;
      level_q  <= '0;
      power_q  <= 1'b0;
      mode_q   <= '0;
      idle_q   <= '0;
      done_q   <= 1'b1;
    end else if (upd_i) begin
      colour_q <= colour_d;
      level_q  <= level_d;
      power_q  <= power_d;
      mode_q   <= mode_d;
      idle_q   <= idle_d;
      done_q   <= done_d;
    end
  end

  assign status_o = '{colour: colour_q, level: level_q, power: power_q, mode: mode_q};

endmodule

// ===== rtl/core/led_dimmer_mode_controller_unit.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// cmd_i     in   valid/ready    opcode[3:0], amount[15:0] signed
// res_o     out  valid/ready    drive_red/green/blue[7:0], level_now[7:0],
//                               power_on, mode_now[2:0]
// cfg       in   cfg_we_i       cfg_idx_i[1:0], cfg_data_i[15:0]
//
// one request per cycle while no stage is stalled; a result goes valid once its request has passed every stage below
// stages: input register, state update, colour x level multiply, /255 and gate
// every stage holds while the one after it is full and stalled
// reset clears state, power off, timer expired, config to its defaults

module led_dimmer_mode_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ldmc_cmd_if.sink                      cmd_i,
  ldmc_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [ldmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ldmc_pkg::CfgW-1:0]     cfg_data_i
);
  import ldmc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_bright: MaxBrightRst, mode_limit: ModeLimitRst, off_time: OffTimeRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_BRIGHT: cfg_q.max_bright <= cfg_data_i[LevelW-1:0];
        CFG_MODE_LIMIT: cfg_q.mode_limit <= cfg_data_i[ModeW-1:0];
        CFG_OFF_TIME:   cfg_q.off_time   <= cfg_data_i[MinuteW-1:0];
        default: ;
      endcase
    end
  end

  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_free, s3_free, s2_free, s1_free;

  assign out_free = !out_v_q || res_o.ready;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_free  = !s1_v_q || s2_free;
  assign cmd_i.ready = s1_free;

  logic [3:0]         op_q;
  logic signed [15:0] amt_q;

  always_ff @(posedge clk_i) begin
    if (s1_free && cmd_i.valid) begin
      op_q  <= cmd_i.opcode;
      amt_q <= cmd_i.amount;
    end
  end

  logic    upd;
  status_t status;

  assign upd = s1_v_q && s2_free;

  ldmc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .upd_i    (upd),
    .op_i     (op_q),
    .amount_i (amt_q),
    .status_o (status)
  );

  // product stage
  logic [2*LevelW-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [LevelW-1:0]   lvl_q;
  logic                pwr_q;
  logic [ModeW-1:0]    mode_q;

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_v_q) begin
      prod_r_q <= status.colour.red   * status.level;
      prod_g_q <= status.colour.green * status.level;
      prod_b_q <= status.colour.blue  * status.level;
      lvl_q    <= status.level;
      pwr_q    <= status.power;
      mode_q   <= status.mode;
    end
  end

  // result register
  logic [LevelW-1:0] red_q, green_q, blue_q, lvl_out_q;
  logic              pwr_out_q;
  logic [ModeW-1:0]  mode_out_q;

  always_ff @(posedge clk_i) begin
    if (out_free && s3_v_q) begin
      red_q      <= pwr_q ? div255(prod_r_q) : '0;
      green_q    <= pwr_q ? div255(prod_g_q) : '0;
      blue_q     <= pwr_q ? div255(prod_b_q) : '0;
      lvl_out_q  <= lvl_q;
      pwr_out_q  <= pwr_q;
      mode_out_q <= mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free)  s1_v_q  <= cmd_i.valid;
      if (s2_free)  s2_v_q  <= s1_v_q;
      if (s3_free)  s3_v_q  <= s2_v_q;
      if (out_free) out_v_q <= s3_v_q;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.drive_red   = red_q;
  assign res_o.drive_green = green_q;
  assign res_o.drive_blue  = blue_q;
  assign res_o.level_now   = lvl_out_q;
  assign res_o.power_on    = pwr_out_q;
  assign res_o.mode_now    = mode_out_q;

  // power off means dark outputs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !pwr_out_q |-> red_q == '0 && green_q == '0 && blue_q == '0)
    else $error("drive level nonzero while power is off");

  // an accepted request always lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> s1_v_q)
    else $error("accepted request lost at input register");

  // state only moves when the update stage can take the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(status))
    else $error("state changed without an update");

  // a finished product reaches the result register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && out_free |=> out_v_q)
    else $error("result dropped between product and output stage");

endmodule
